// File: sv/lsc_pkg.sv
package lsc_pkg;

  typedef enum logic [2:0] {
    OP_ACCESS = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_TOUCH  = 3'd2,
    OP_BTOUCH = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FLUSH  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ABS   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] key_x;
    logic signed [15:0] key_y;
    logic signed [15:0] key_z;
    logic [31:0]        batch_tag;
    logic               keep_clean;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         slot;
    logic               victim_valid;
    logic signed [15:0] victim_x;
    logic signed [15:0] victim_y;
    logic signed [15:0] victim_z;
    logic               victim_dirty;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [47:0] key;
    logic [63:0] age;
    logic [31:0] batch;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_OUT
  } state_t;

endpackage

// File: sv/lsc_ram.sv
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lru_slot_cache_with_batch_pinning.sv
// Each request scans the entry memory, one slot a cycle unless an output stall
// holds a flush beat, and then goes through the write state. Flush beats
// leave during the scan, each one dirty entry behind; the last at the write.
// A request is taken only when idle, after the last result is taken; output
// stalls hold the scan at a flush beat and the write. Synchronous reset clears
// the valid and dirty bits, counts and age counter; memories are not cleared.
module lru_slot_cache_with_batch_pinning #(
  parameter int SLOTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lsc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lsc_pkg::rsp_t out_data,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  lsc_pkg::state_t  state, state_next;
  lsc_pkg::req_t    req;
  logic [5:0]       active;
  logic [6:0]       eff;
  logic [SLOTS-1:0] vld, drt;
  logic [CW-1:0]    free_count, used_count;
  logic [AW-1:0]    free_head;
  logic [63:0]      age_counter;
  logic [AW-1:0]    cidx;
  logic             found;
  logic [AW-1:0]    fslot;
  logic [31:0]      fbatch;
  logic             vfound;
  logic [AW-1:0]    vslot;
  logic [63:0]      vage;
  logic [47:0]      vkey;
  logic             pend_valid;
  lsc_pkg::rsp_t    pend;
  logic             ew;
  logic [AW-1:0]    ewa, era;
  lsc_pkg::ent_t    ewd, erd;
  logic             fw;
  logic [AW-1:0]    fwa, fwd, frd;
  logic [AW:0]      fpos;
  logic [AW-1:0]    newslot;
  lsc_pkg::rsp_t    rsp, out_next;
  logic [47:0]      rkey;
  logic             fire_out, out_free, out_load;
  logic             hit_now, cand_now, wb_now, bt_now;
  logic             hold, scan_end, commit, age_inc, has_room;

  assign rkey = {req.key_z, req.key_y, req.key_x};
  assign in_stall = (state != lsc_pkg::S_IDLE);
  assign fire_out = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (active == 6'd0) eff = 7'd1;
    else if (32'(active) > SLOTS) eff = 7'(SLOTS);
    else eff = {1'b0, active};
  end

  lsc_ram #(.WIDTH($bits(lsc_pkg::ent_t)), .DEPTH(SLOTS)) u_ent (
    .clk(clk), .we(ew), .waddr(ewa), .wdata(ewd), .raddr(era), .rdata(erd)
  );

  lsc_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_free (
    .clk(clk), .we(fw), .waddr(fwa), .wdata(fwd), .raddr(free_head), .rdata(frd)
  );

  assign hit_now  = vld[cidx] && erd.key == rkey;
  assign cand_now = vld[cidx] && !(req.batch_tag != 32'd0 && erd.batch == req.batch_tag);
  assign wb_now   = req.op == lsc_pkg::OP_FLUSH && vld[cidx] && drt[cidx];
  assign bt_now   = req.op == lsc_pkg::OP_BTOUCH && vld[cidx] && erd.batch == req.batch_tag;
  assign hold     = (state == lsc_pkg::S_SCAN) && wb_now && pend_valid && !out_free;
  assign scan_end = (cidx == AW'(SLOTS - 1));
  assign commit   = (state == lsc_pkg::S_WRITE) && out_free;
  assign has_room = 32'(used_count) < 32'(eff);
  assign newslot  = (free_count != '0) ? frd : AW'(used_count);

  // held scan rereads the same slot
  always_comb begin
    era = cidx;
    if (state == lsc_pkg::S_SCAN && !hold && !scan_end) era = cidx + 1'b1;
  end

  always_comb begin
    fpos = (AW+1)'(free_head) + (AW+1)'(free_count);
    if (32'(fpos) >= SLOTS) fpos = fpos - (AW+1)'(SLOTS);
  end

  assign fw  = commit && req.op == lsc_pkg::OP_REMOVE && found && 32'(free_count) < SLOTS;
  assign fwa = fpos[AW-1:0];
  assign fwd = fslot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lsc_pkg::S_IDLE:  if (in_valid) state_next = lsc_pkg::S_SCAN;
      lsc_pkg::S_SCAN:  if (!hold && scan_end) state_next = lsc_pkg::S_WRITE;
      lsc_pkg::S_WRITE: if (out_free) state_next = lsc_pkg::S_OUT;
      lsc_pkg::S_OUT:   if (out_free) state_next = lsc_pkg::S_IDLE;
      default:          state_next = lsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ew = 1'b0;
    ewa = fslot;
    ewd = '{rkey, age_counter, req.batch_tag};
    age_inc = 1'b0;
    rsp = '{lsc_pkg::ST_DONE, 5'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1};
    unique case (req.op)
      lsc_pkg::OP_ACCESS: begin
        if (found) begin
          ew = 1'b1;
          age_inc = 1'b1;
          ewd.batch = (req.batch_tag != 32'd0) ? req.batch_tag : fbatch;
          rsp.status = lsc_pkg::ST_HIT;
          rsp.slot = 5'(fslot);
        end else if (has_room) begin
          ew = 1'b1;
          ewa = newslot;
          age_inc = 1'b1;
          rsp.status = lsc_pkg::ST_NEW;
          rsp.slot = 5'(newslot);
        end else if (vfound) begin
          ew = 1'b1;
          ewa = vslot;
          age_inc = 1'b1;
          rsp = '{lsc_pkg::ST_NEW, 5'(vslot), 1'b1, vkey[15:0], vkey[31:16],
                  vkey[47:32], drt[vslot], 1'b1};
        end else begin
          rsp.status = lsc_pkg::ST_FULL;
        end
      end
      lsc_pkg::OP_LOOKUP: begin
        rsp.status = found ? lsc_pkg::ST_HIT : lsc_pkg::ST_ABS;
        rsp.slot = found ? 5'(fslot) : 5'd0;
      end
      lsc_pkg::OP_TOUCH: begin
        if (found) begin
          ew = 1'b1;
          age_inc = 1'b1;
          ewd.batch = fbatch;
          rsp.status = lsc_pkg::ST_HIT;
          rsp.slot = 5'(fslot);
        end else begin
          rsp.status = lsc_pkg::ST_ABS;
        end
      end
      lsc_pkg::OP_BTOUCH: begin
        age_inc = 1'b1;
      end
      lsc_pkg::OP_REMOVE: begin
        rsp.status = found ? lsc_pkg::ST_DONE : lsc_pkg::ST_ABS;
        rsp.slot = found ? 5'(fslot) : 5'd0;
      end
      lsc_pkg::OP_FLUSH: begin
        if (pend_valid) begin
          rsp = pend;
          rsp.last = 1'b1;
        end
      end
      default: ;
    endcase
    if (!commit) begin
      ew = 1'b0;
      age_inc = 1'b0;
    end
    // batch touch rewrites matching entries during the scan
    if (state == lsc_pkg::S_SCAN && !hold && bt_now) begin
      ew = 1'b1;
      ewa = cidx;
      ewd = '{erd.key, age_counter, erd.batch};
    end
  end

  assign out_next = (state == lsc_pkg::S_WRITE) ? rsp : pend;
  assign out_load = commit ||
                    (state == lsc_pkg::S_SCAN && wb_now && pend_valid && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 6'd32;
      vld <= '0;
      drt <= '0;
      free_count <= '0;
      used_count <= '0;
      free_head <= '0;
      age_counter <= '0;
      out_valid <= 1'b0;
      cidx <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) active <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
        out_data <= out_next;
      end else if (fire_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lsc_pkg::S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            found <= 1'b0;
            vfound <= 1'b0;
            pend_valid <= 1'b0;
          end
        end
        lsc_pkg::S_SCAN: begin
          if (!hold) begin
            if (hit_now && !found) begin
              found <= 1'b1;
              fslot <= cidx;
              fbatch <= erd.batch;
            end
            if (cand_now && (!vfound || erd.age < vage)) begin
              vfound <= 1'b1;
              vslot <= cidx;
              vage <= erd.age;
              vkey <= erd.key;
            end
            if (wb_now) begin
              pend_valid <= 1'b1;
              pend <= '{lsc_pkg::ST_WB, 5'(cidx), 1'b1, erd.key[15:0],
                        erd.key[31:16], erd.key[47:32], 1'b1, 1'b0};
            end
            if (req.op == lsc_pkg::OP_FLUSH) drt[cidx] <= 1'b0;
            cidx <= scan_end ? '0 : cidx + 1'b1;
          end
        end
        lsc_pkg::S_WRITE: begin
          if (commit) begin
            if (age_inc) age_counter <= age_counter + 64'd1;
            unique case (req.op)
              lsc_pkg::OP_ACCESS: begin
                if (found) begin
                  if (!req.keep_clean) drt[fslot] <= 1'b1;
                end else if (has_room) begin
                  used_count <= used_count + 1'b1;
                  vld[newslot] <= 1'b1;
                  drt[newslot] <= !req.keep_clean;
                  if (free_count != '0) begin
                    free_count <= free_count - 1'b1;
                    free_head <= (32'(free_head) == SLOTS - 1) ? '0 : free_head + 1'b1;
                  end
                end else if (vfound) begin
                  drt[vslot] <= !req.keep_clean;
                end
              end
              lsc_pkg::OP_REMOVE: begin
                if (found) begin
                  if (32'(free_count) < SLOTS) free_count <= free_count + 1'b1;
                  vld[fslot] <= 1'b0;
                  drt[fslot] <= 1'b0;
                  if (used_count != '0) used_count <= used_count - 1'b1;
                end
              end
              lsc_pkg::OP_CLEAR: begin
                vld <= '0;
                drt <= '0;
                free_count <= '0;
                free_head <= '0;
                used_count <= '0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule
